FILE: src/pfc_pkg.sv
// shared types and constants for the prime factor counter
// no dependencies; imported by every module of the block
package pfc_pkg;

	localparam int VALUE_WIDTH = 40;
	localparam int COUNT_WIDTH = 6;
	// trial divisor never exceeds the square root of the value plus two
	localparam int DIV_WIDTH   = VALUE_WIDTH / 2 + 2;
	localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH);

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [DIV_WIDTH-1:0]   divisor_t;
	typedef logic [STEP_WIDTH-1:0]  step_t;

	localparam step_t    STEP_LAST  = step_t'(VALUE_WIDTH - 1);
	localparam divisor_t FIRST_ODD  = divisor_t'(3);
	localparam divisor_t ODD_STRIDE = divisor_t'(2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STRIP,
		ST_START,
		ST_DIV,
		ST_CHECK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic strip;
		logic div_start;
		logic div_step;
		logic take_q;
		logic next_d;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic rest_zero;
		logic rest_lsb;
		logic div_last;
		logic d_gt_q;
		logic rem_zero;
	} status_t;

endpackage

FILE: src/pfc_datapath.sv
// datapath: remaining value, factor count, trial divisor and a
// one-bit-per-cycle restoring divider; depends on pfc_pkg
module pfc_datapath (
	input  logic             clk,
	input  pfc_pkg::value_t  value,
	input  pfc_pkg::cmd_t    cmd,
	output pfc_pkg::status_t status,
	output pfc_pkg::count_t  factor_count
);
	import pfc_pkg::*;

	value_t   rest_q;
	count_t   count_q;
	divisor_t div_q;
	divisor_t rem_q;
	value_t   quo_q;
	step_t    step_q;
	count_t   factor_count_q;

	logic [DIV_WIDTH:0] shifted;
	logic [DIV_WIDTH:0] diff;
	logic               quo_bit;
	value_t             div_ext;

	assign shifted = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign quo_bit = ~diff[DIV_WIDTH];
	assign div_ext = value_t'(div_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rest_q  <= value;
			count_q <= '0;
			div_q   <= FIRST_ODD;
		end else if (cmd.strip) begin
			rest_q  <= rest_q >> 1;
			count_q <= count_q + count_t'(1);
		end else if (cmd.take_q) begin
			rest_q  <= quo_q;
			count_q <= count_q + count_t'(1);
		end else if (cmd.next_d) begin
			div_q <= div_q + ODD_STRIDE;
		end

		if (cmd.div_start) begin
			quo_q  <= rest_q;
			rem_q  <= '0;
			step_q <= STEP_LAST;
		end else if (cmd.div_step) begin
			quo_q  <= {quo_q[VALUE_WIDTH-2:0], quo_bit};
			rem_q  <= quo_bit ? diff[DIV_WIDTH-1:0] : shifted[DIV_WIDTH-1:0];
			step_q <= step_q - step_t'(1);
		end

		// leftover other than one is counted as a last prime
		if (cmd.emit) begin
			factor_count_q <= count_q + count_t'(rest_q != value_t'(1));
		end
	end

	always_comb begin
		status.rest_zero = (rest_q == '0);
		status.rest_lsb  = rest_q[0];
		status.div_last  = (step_q == '0);
		status.d_gt_q    = (div_ext > quo_q);
		status.rem_zero  = (rem_q == '0);
	end

	assign factor_count = factor_count_q;

`ifndef SYNTHESIS
	logic arst_free;
	assign arst_free = 1'b0;

	a_rem_below_div: assert property (@(posedge clk) disable iff (arst_free)
		$past(cmd.div_step) |-> rem_q < div_q)
		else $error("divider remainder not below divisor");

	a_div_odd: assert property (@(posedge clk) disable iff (arst_free)
		cmd.div_start |-> div_q[0] && div_q >= FIRST_ODD)
		else $error("trial divisor not odd or below three");

	a_strip_even: assert property (@(posedge clk) disable iff (arst_free)
		cmd.strip |-> !rest_q[0] && rest_q != '0)
		else $error("factor of two stripped from odd or zero value");
`endif

endmodule

FILE: src/pfc_ctrl.sv
// controller: sequences load, strip of twos, trial divisions and result
// hand-off, and owns both handshakes; depends on pfc_pkg
module pfc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  pfc_pkg::status_t status,
	output pfc_pkg::cmd_t    cmd
);
	import pfc_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_STRIP;
			end
			ST_STRIP: begin
				if (status.rest_zero || status.rest_lsb) state_d = ST_START;
			end
			ST_START: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_last) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (status.d_gt_q) state_d = ST_FINISH;
				else state_d = ST_START;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_STRIP: begin
				cmd.strip = !(status.rest_zero || status.rest_lsb);
			end
			ST_START: begin
				cmd.div_start = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_CHECK: begin
				// divisor past the square root ends the search
				cmd.take_q = !status.d_gt_q && status.rem_zero;
				cmd.next_d = !status.d_gt_q && !status.rem_zero;
			end
			ST_FINISH: begin
				cmd.emit = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_accept_strip: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_STRIP)
		else $error("accepted request did not start stripping");

	a_emit_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish");

	a_div_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && status.div_last |=> state_q == ST_CHECK)
		else $error("division did not end in check");
`endif

endmodule

FILE: src/prime_factor_count.sv
// prime factor count by trial division: controller plus serial-divider datapath
// each trial division runs the serial divider at one quotient bit per cycle
// worst case about 2^19 odd divisors are tried for a 40-bit prime
// one request at a time; the next is taken while a result waits to be read
// arst_n clears the controller and output valid; data registers are not reset
module prime_factor_count (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  pfc_pkg::value_t       value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output pfc_pkg::count_t       factor_count
);
	import pfc_pkg::*;

	cmd_t    cmd;
	status_t status;

	pfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	pfc_datapath u_datapath (
		.clk          (clk),
		.value        (value),
		.cmd          (cmd),
		.status       (status),
		.factor_count (factor_count)
	);

endmodule

FILE: test/prime_factor_count_checker.sv
// checker for prime_factor_count: watches both channels, predicts each factor count
// and compares it with the result that comes back; depends on pfc_pkg
module prime_factor_count_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_stall,
	input  pfc_pkg::value_t value,
	input  logic            out_valid,
	input  logic            out_stall,
	input  pfc_pkg::count_t factor_count,
	output int              fail_count,
	output int              pending
);

	timeunit 1ns;
	timeprecision 1ps;

	import pfc_pkg::*;

	typedef struct packed {
		value_t value;
		count_t count;
	} factor_request_t;

	factor_request_t expected_counts[$];
	factor_request_t oldest;

	// trial division with multiplicity, 2 stripped first, then odd divisors
	function automatic count_t count_prime_factors(value_t v);
		logic [63:0] rest;
		logic [63:0] d;
		int unsigned n;
		rest = 64'(v);
		n = 0;
		if (rest != 0) begin
			while (rest[0] == 1'b0) begin
				rest = rest >> 1;
				n++;
			end
		end
		for (d = 3; d <= rest / d; d = d + 2) begin
			while (rest % d == 0) begin
				rest = rest / d;
				n++;
			end
		end
		// whatever is left other than one is counted as the last prime
		if (rest != 1)
			n++;
		return count_t'(n);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_counts.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_counts.size() == 0) begin
					$display("%t: unexpected factor_count %0d, expected none",
						$time, factor_count);
					fail_count <= fail_count + 1;
				end else begin
					oldest = expected_counts.pop_front();
					if (factor_count !== oldest.count) begin
						$display("%t: factor_count for value %0d: expected %0d, actual %0d",
							$time, oldest.value, oldest.count, factor_count);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_counts.insert(expected_counts.size(),
					'{value, count_prime_factors(value)});
			pending <= expected_counts.size();
		end
	end

endmodule

FILE: test/prime_factor_count_test.sv
// top of the prime_factor_count testbench: clock, reset, requests and verdict
// depends on pfc_pkg, prime_factor_count and prime_factor_count_checker
module prime_factor_count_test;

	timeunit 1ns;
	timeprecision 1ps;

	import pfc_pkg::*;

	localparam value_t VALUE_MAX = '1;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	value_t value = '0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	count_t factor_count;
	int     fail_count;
	int     pending;

	int idle_pct = 0;
	int stall_pct = 0;
	int idle_plan[4] = '{0, 45, 0, 31};
	int stall_plan[4] = '{0, 0, 45, 31};

	int unsigned small_primes[25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
		43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

	// one, zero, powers, squares of primes, all ones, primes, semiprimes and a primorial
	value_t corner_values[20] = '{
		40'd1, 40'd0, 40'd2, 40'd3, 40'd4, 40'd6, 40'd9, 40'd25, 40'd49, 40'd121,
		40'd63001, 40'h80_0000_0000, 40'hC0_0000_0000, 40'hFF_FFFF_FFFF,
		40'd847288609443, 40'd832972004929, 40'd200560490130,
		40'd1048573, 40'd1052651, 40'd16777213
	};

	prime_factor_count u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.factor_count (factor_count)
	);

	prime_factor_count_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.factor_count (factor_count),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// mostly smooth values so trial division stays short; the optional cofactor
	// below 2^16 keeps the largest divisor tried near 256
	function automatic value_t random_value();
		logic [63:0] acc;
		logic [63:0] p;
		int tries;
		acc = 1;
		if ($urandom_range(9) == 0)
			return value_t'($urandom_range(262143, 1));
		if ($urandom_range(2) == 0)
			acc = 64'($urandom_range(65535, 2));
		tries = $urandom_range(1) ? 64 : int'($urandom_range(8, 1));
		repeat (tries) begin
			p = 64'(small_primes[$urandom_range(24)]);
			if (acc * p <= 64'(VALUE_MAX))
				acc = acc * p;
		end
		return value_t'(acc);
	endfunction

	task automatic send_value(input value_t v);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_values[i])
			send_value(corner_values[i]);

		for (int phase = 0; phase < 4; phase++) begin
			idle_pct  = idle_plan[phase];
			stall_pct = stall_plan[phase];
			repeat (25)
				send_value(random_value());
		end
		in_valid <= 1'b0;

		// pending is a registered copy of the queue size, so let the last request show up
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2_000_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
